### hw/rtl/hst_pkg.sv
// Shared widths and pipeline depth for the ray-sphere hit test.
`default_nettype none
package hst_pkg;
	localparam int unsigned CoordW = 32;
	localparam int unsigned LenW = 31;
	localparam int unsigned DiffW = CoordW + 1;
	localparam int unsigned BW = 2 * DiffW + 1;
	localparam int unsigned CW = 2 * DiffW + 3;
	localparam int unsigned BLoW = 34;
	localparam int unsigned BHiW = BW - BLoW;
	localparam int unsigned SqW = 136;
	localparam int unsigned GW = 104;
	localparam int unsigned Latency = 7;
	typedef logic signed [DiffW-1:0] diff_t;
endpackage
`default_nettype wire

### hw/rtl/hst_mul_cell.sv
// Registered signed multiplier cell.
`default_nettype none
module hst_mul_cell #(
	parameter int unsigned AW = 32,
	parameter int unsigned BWid = 32
) (
	input  wire                         clk,
	input  wire logic signed [AW-1:0]   a,
	input  wire logic signed [BWid-1:0] b,
	output logic signed [AW+BWid-1:0]   p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
`default_nettype wire

### hw/rtl/ray_sphere_hit_test.sv
// Top level of the ray-sphere hit test pipeline.
// The done strobe is the tail of the valid shift chain that samples start alongside the data registers.
// Throughput: one word per cycle; busy stays low, set by the fixed multiplier chain.
// Each result shows for one cycle on hit with done; the receiver cannot stall.
// Reset clears the valid chain only; words in flight are dropped.
`default_nettype none
module ray_sphere_hit_test import hst_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire logic [CoordW-1:0]   origin_x,
	input  wire logic [CoordW-1:0]   origin_y,
	input  wire logic [CoordW-1:0]   origin_z,
	input  wire logic [CoordW-1:0]   dir_x,
	input  wire logic [CoordW-1:0]   dir_y,
	input  wire logic [CoordW-1:0]   dir_z,
	input  wire logic [LenW-1:0]     ray_reach,
	input  wire logic [CoordW-1:0]   center_x,
	input  wire logic [CoordW-1:0]   center_y,
	input  wire logic [CoordW-1:0]   center_z,
	input  wire logic [LenW-1:0]     sphere_radius,
	output logic                     hit,
	output logic                     done
);
	logic [Latency-1:0] vld_q;
	diff_t mx_s1, my_s1, mz_s1;
	logic signed [CoordW-1:0] dx_s1, dy_s1, dz_s1;
	logic [LenW-1:0] l_s1, r_s1, l_s2, l_s3;
	logic signed [2*DiffW-2:0] pbx_s2, pby_s2, pbz_s2;
	logic signed [2*DiffW-1:0] qx_s2, qy_s2, qz_s2;
	logic signed [2*CoordW-1:0] rr_s2;
	logic signed [BW-1:0] b_s3, b_s4;
	logic signed [CW-1:0] c_s3, c_s4, c_s5;
	logic [LenW-1:0] l_s4;
	logic signed [2*BHiW-1:0] hh_s4;
	logic signed [BHiW+BLoW:0] hl_s4;
	logic signed [2*BLoW+1:0] ll_s4;
	logic signed [BHiW+CoordW-1:0] hL_s4;
	logic signed [BLoW+CoordW:0] lL_s4;
	logic signed [2*CoordW-1:0] LL_s4;
	logic signed [SqW-1:0] sq_s5;
	logic signed [GW-1:0] bl_s5, lsq_s5;
	logic bneg_s5, cge_s5, cle_s5, blq_s5;
	logic bneg_s6, cge_s6, cle_s6, blq_s6, eneg_s6, gle_s6, gge_s6;
	logic hit_q;
	logic signed [BW+1:0] blq_w;
	logic signed [SqW-1:0] e_w;
	logic signed [GW-1:0] g_w;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Latency-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		mx_s1 <= diff_t'($signed({origin_x[CoordW-1], origin_x}))
			- diff_t'($signed({center_x[CoordW-1], center_x}));
		my_s1 <= diff_t'($signed({origin_y[CoordW-1], origin_y}))
			- diff_t'($signed({center_y[CoordW-1], center_y}));
		mz_s1 <= diff_t'($signed({origin_z[CoordW-1], origin_z}))
			- diff_t'($signed({center_z[CoordW-1], center_z}));
		dx_s1 <= $signed(dir_x);
		dy_s1 <= $signed(dir_y);
		dz_s1 <= $signed(dir_z);
		l_s1 <= ray_reach;
		r_s1 <= sphere_radius;
		l_s2 <= l_s1;
	end

	hst_mul_cell #(.AW(CoordW), .BWid(DiffW)) u_pbx (.clk, .a(dx_s1), .b(mx_s1), .p(pbx_s2));
	hst_mul_cell #(.AW(CoordW), .BWid(DiffW)) u_pby (.clk, .a(dy_s1), .b(my_s1), .p(pby_s2));
	hst_mul_cell #(.AW(CoordW), .BWid(DiffW)) u_pbz (.clk, .a(dz_s1), .b(mz_s1), .p(pbz_s2));
	hst_mul_cell #(.AW(DiffW), .BWid(DiffW)) u_qx (.clk, .a(mx_s1), .b(mx_s1), .p(qx_s2));
	hst_mul_cell #(.AW(DiffW), .BWid(DiffW)) u_qy (.clk, .a(my_s1), .b(my_s1), .p(qy_s2));
	hst_mul_cell #(.AW(DiffW), .BWid(DiffW)) u_qz (.clk, .a(mz_s1), .b(mz_s1), .p(qz_s2));
	hst_mul_cell #(.AW(CoordW), .BWid(CoordW)) u_rr (.clk,
		.a($signed({1'b0, r_s1})), .b($signed({1'b0, r_s1})), .p(rr_s2));

	always_ff @(posedge clk) begin
		b_s3 <= BW'(pbx_s2) + BW'(pby_s2) + BW'(pbz_s2);
		c_s3 <= CW'(qx_s2) + CW'(qy_s2) + CW'(qz_s2) - CW'(rr_s2);
		l_s3 <= l_s2;
	end

	hst_mul_cell #(.AW(BHiW), .BWid(BHiW)) u_hh (.clk,
		.a(b_s3[BW-1:BLoW]), .b(b_s3[BW-1:BLoW]), .p(hh_s4));
	hst_mul_cell #(.AW(BHiW), .BWid(BLoW+1)) u_hl (.clk,
		.a(b_s3[BW-1:BLoW]), .b($signed({1'b0, b_s3[BLoW-1:0]})), .p(hl_s4));
	hst_mul_cell #(.AW(BLoW+1), .BWid(BLoW+1)) u_ll (.clk,
		.a($signed({1'b0, b_s3[BLoW-1:0]})), .b($signed({1'b0, b_s3[BLoW-1:0]})),
		.p(ll_s4));
	hst_mul_cell #(.AW(BHiW), .BWid(CoordW)) u_hL (.clk,
		.a(b_s3[BW-1:BLoW]), .b($signed({1'b0, l_s3})), .p(hL_s4));
	hst_mul_cell #(.AW(BLoW+1), .BWid(CoordW)) u_lL (.clk,
		.a($signed({1'b0, b_s3[BLoW-1:0]})), .b($signed({1'b0, l_s3})), .p(lL_s4));
	hst_mul_cell #(.AW(CoordW), .BWid(CoordW)) u_LL (.clk,
		.a($signed({1'b0, l_s3})), .b($signed({1'b0, l_s3})), .p(LL_s4));

	always_ff @(posedge clk) begin
		b_s4 <= b_s3;
		c_s4 <= c_s3;
		l_s4 <= l_s3;
	end

	assign blq_w = (BW+2)'(b_s4) + (BW+2)'($signed({1'b0, l_s4, 16'h0000}));

	always_ff @(posedge clk) begin
		sq_s5 <= (SqW'(hh_s4) <<< (2*BLoW)) + (SqW'(hl_s4) <<< (BLoW+1)) + SqW'(ll_s4);
		bl_s5 <= (GW'(hL_s4) <<< BLoW) + GW'(lL_s4);
		lsq_s5 <= GW'(LL_s4);
		c_s5 <= c_s4;
		bneg_s5 <= b_s4[BW-1] || (b_s4 == '0);
		cge_s5 <= !c_s4[CW-1];
		cle_s5 <= c_s4[CW-1] || (c_s4 == '0);
		blq_s5 <= !blq_w[BW+1];
	end

	assign e_w = sq_s5 - (SqW'(c_s5) <<< 32);
	assign g_w = (lsq_s5 <<< 16) + (bl_s5 <<< 1) + (GW'(c_s5) <<< 16);

	always_ff @(posedge clk) begin
		eneg_s6 <= e_w[SqW-1];
		gle_s6 <= g_w[GW-1] || (g_w == '0);
		gge_s6 <= !g_w[GW-1];
		bneg_s6 <= bneg_s5;
		cge_s6 <= cge_s5;
		cle_s6 <= cle_s5;
		blq_s6 <= blq_s5;
	end

	always_ff @(posedge clk) begin
		hit_q <= !eneg_s6 && ((bneg_s6 && cge_s6 && (blq_s6 || gle_s6))
			|| ((bneg_s6 || cle_s6) && blq_s6 && gge_s6));
	end

	assign done = vld_q[Latency-1];
	assign hit = done & hit_q;
endmodule
`default_nettype wire

### hw/rtl/hst_checker.sv
// Port-level checks for the ray-sphere hit test, bound to the top level.
`default_nettype none
module hst_checker import hst_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire hit,
	input wire done
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, Latency))
		else $error("done without an accepted word");
	a_hit_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !hit)
		else $error("hit outside done");
endmodule

bind ray_sphere_hit_test hst_checker u_hst_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .hit(hit), .done(done)
);
`default_nettype wire

### tb/ray_sphere_hit_test_tb.sv
// Self-checking testbench for the ray-sphere hit test pipeline.
`timescale 1ns / 100ps
`default_nettype none
module ray_sphere_hit_test_tb;
	import hst_pkg::*;

	localparam int unsigned IdleLimit = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [CoordW-1:0] origin_x, origin_y, origin_z;
	logic [CoordW-1:0] dir_x, dir_y, dir_z;
	logic [LenW-1:0] ray_reach;
	logic [CoordW-1:0] center_x, center_y, center_z;
	logic [LenW-1:0] sphere_radius;
	logic hit;
	logic done;

	typedef struct {
		logic [CoordW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
		logic [LenW-1:0] reach, radius;
	} ray_pair_t;

	logic hits_due[$];
	int unsigned mismatches;
	int unsigned idle_cycles;

	ray_sphere_hit_test uut (
		.clk, .arst_n, .start, .busy,
		.origin_x, .origin_y, .origin_z,
		.dir_x, .dir_y, .dir_z, .ray_reach,
		.center_x, .center_y, .center_z, .sphere_radius,
		.hit, .done
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic predict_hit(ray_pair_t p);
		logic signed [255:0] mx, my, mz, b, c, e, g, bq, rr, ll;
		logic first_ok, second_ok;
		mx = $signed(p.ox) - $signed(p.cx);
		my = $signed(p.oy) - $signed(p.cy);
		mz = $signed(p.oz) - $signed(p.cz);
		b = $signed(p.dx) * mx + $signed(p.dy) * my + $signed(p.dz) * mz;
		rr = {225'd0, p.radius};
		ll = {225'd0, p.reach};
		c = mx * mx + my * my + mz * mz - rr * rr;
		e = b * b - (c <<< 32);
		if (e < 0)
			return 1'b0;
		bq = b + (ll <<< 16);
		g = ((ll * ll) <<< 16) + 2 * b * ll + (c <<< 16);
		first_ok = b <= 0 && c >= 0 && (bq >= 0 || g <= 0);
		second_ok = (b <= 0 || c <= 0) && bq >= 0 && g >= 0;
		return first_ok || second_ok;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (hits_due.size() == 0)
				report_mismatch("hit word with nothing pending");
			else begin
				logic want;
				want = hits_due.pop_front();
				if (hit !== want)
					report_mismatch($sformatf("hit %b, want %b", hit, want));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("ray_sphere_hit_test verification failed");
			$finish;
		end
	end

	task automatic send_pair(ray_pair_t p, bit keep_start);
		origin_x <= p.ox; origin_y <= p.oy; origin_z <= p.oz;
		dir_x <= p.dx; dir_y <= p.dy; dir_z <= p.dz; ray_reach <= p.reach;
		center_x <= p.cx; center_y <= p.cy; center_z <= p.cz;
		sphere_radius <= p.radius;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		hits_due.push_back(predict_hit(p));
		@(negedge clk);
		if (!keep_start)
			start <= 1'b0;
	endtask

	function automatic ray_pair_t make_pair(int q, int dlen, int r, int l);
		ray_pair_t p;
		p.ox = q; p.oy = 0; p.oz = 0;
		p.dx = dlen; p.dy = 0; p.dz = 0;
		p.cx = 0; p.cy = 0; p.cz = 0;
		p.radius = LenW'(r); p.reach = LenW'(l);
		return p;
	endfunction

	function automatic ray_pair_t rand_pair();
		ray_pair_t p;
		int unsigned mode;
		mode = $urandom_range(0, 3);
		p.ox = $urandom; p.oy = $urandom; p.oz = $urandom;
		p.dx = $urandom; p.dy = $urandom; p.dz = $urandom;
		p.cx = $urandom; p.cy = $urandom; p.cz = $urandom;
		p.reach = LenW'($urandom); p.radius = LenW'($urandom);
		if (mode != 0) begin
			// near geometry: small offsets, near-unit direction
			p.cx = p.ox + $signed($urandom_range(0, 40 << 16)) - (20 << 16);
			p.cy = p.oy + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
			p.cz = p.oz + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
			p.dx = (mode == 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			p.dy = $signed($urandom_range(0, 2048)) - 1024;
			p.dz = $signed($urandom_range(0, 2048)) - 1024;
			p.radius = LenW'($urandom_range(0, 6 << 16));
			p.reach = LenW'($urandom_range(0, 30 << 16));
		end
		return p;
	endfunction

	task automatic test_directed();
		ray_pair_t p;
		send_pair(make_pair(-(10 << 16), 1 << 16, 2 << 16, 20 << 16), 1'b1);
		send_pair(make_pair(-(10 << 16), 1 << 16, 2 << 16, 5 << 16), 1'b1);
		send_pair(make_pair(-(10 << 16), -(1 << 16), 2 << 16, 20 << 16), 1'b1);
		send_pair(make_pair(0, 1 << 16, 2 << 16, 1 << 16), 1'b1);
		send_pair(make_pair(0, 1 << 16, 2 << 16, 2 << 16), 1'b1);
		send_pair(make_pair(-(10 << 16), 1 << 16, 2 << 16, 8 << 16), 1'b1);
		send_pair(make_pair(-(10 << 16), 1 << 16, 0, 10 << 16), 1'b1);
		send_pair(make_pair(-(10 << 16), 2 << 16, 2 << 16, 5 << 16), 1'b1);
		p = make_pair(-(10 << 16), 1 << 16, 2 << 16, 20 << 16);
		p.oy = 2 << 16;
		send_pair(p, 1'b1);
		p.oy = (2 << 16) + 1;
		send_pair(p, 1'b1);
		send_pair(make_pair(0, 0, 0, 0), 1'b1);
		p = make_pair(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		p.oy = 32'h8000_0000; p.oz = 32'h8000_0000;
		p.dy = 32'h8000_0000; p.dz = 32'h8000_0000;
		p.cx = 32'h7FFF_FFFF; p.cy = 32'h7FFF_FFFF; p.cz = 32'h7FFF_FFFF;
		send_pair(p, 1'b1);
		p.ox = 32'h7FFF_FFFF; p.oy = 32'h7FFF_FFFF; p.oz = 32'h7FFF_FFFF;
		p.dx = 32'h7FFF_FFFF; p.dy = 32'h7FFF_FFFF; p.dz = 32'h7FFF_FFFF;
		p.cx = 32'h8000_0000; p.cy = 32'h8000_0000; p.cz = 32'h8000_0000;
		send_pair(p, 1'b1);
		p.radius = 0; p.reach = 0;
		send_pair(p, 1'b0);
	endtask

	task automatic test_random(int unsigned count);
		int unsigned sent, burst;
		sent = 0;
		while (sent < count) begin
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst = $urandom_range(1, 20);
			while (burst > 0 && sent < count) begin
				burst--;
				sent++;
				send_pair(rand_pair(), burst > 0 && sent < count);
			end
		end
	endtask

	task automatic drain();
		while (hits_due.size() != 0)
			@(negedge clk);
		repeat (Latency + 3) @(negedge clk);
	endtask

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
		{center_x, center_y, center_z} = '0;
		ray_reach = '0;
		sphere_radius = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(450);
		drain();
		if (mismatches == 0)
			$display("ray_sphere_hit_test verification clean");
		else
			$display("ray_sphere_hit_test verification failed");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
hw/rtl/hst_pkg.sv
hw/rtl/hst_mul_cell.sv
hw/rtl/ray_sphere_hit_test.sv
hw/rtl/hst_checker.sv
tb/ray_sphere_hit_test_tb.sv
